// File: sv/jfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared widths, register indexes, reset values and record types for the
// five-point Jacobi sweep unit.
// ----------------------------------------------------------------------------
package jfs_pkg;

  // Payload widths fixed by the interface
  localparam int VAL_W     = 32;
  localparam int ROW_OUT_W = 11;
  localparam int COL_OUT_W = 10;

  // Configuration register widths and port
  localparam int GCOLS_W    = 11;
  localparam int GROWS_W    = 12;
  localparam int INV_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DIAG  = 2'd2;

  localparam logic [GCOLS_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [GROWS_W-1:0] GRID_ROWS_RST = 12'd2048;
  localparam logic [INV_W-1:0]   INV_DIAG_RST  = 17'd13107;

  // Default grid limits
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 2048;

  // Width used for counter and size comparisons (covers every legal limit)
  localparam int CMP_W = 16;

  // Stencil arithmetic: five 32-bit terms, Q1.16 reciprocal
  localparam int SUM_W     = VAL_W + 3;
  localparam int PROD_W    = SUM_W + INV_W + 1;
  localparam int INV_SHIFT = 16;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Per-point control carried down the pipeline
  typedef struct packed {
    logic                 has_a;   // stencil/boundary result of the row above
    logic                 has_b;   // last-row pass-through result
    logic                 bnd;     // row-above point lies on the grid edge
    logic                 done;    // last column of a row (final grid point on the last row)
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } ctl_t;

  // One result record
  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 bnd;
    logic                 last;
    logic                 done;
  } res_t;

endpackage

// File: sv/jfs_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_linebuf
// Three column-indexed line memories (row above, row two above, source term
// of the row above). Reads are issued on the accepting edge; the write-back
// of the point follows in the next cycle.
// ----------------------------------------------------------------------------
module jfs_linebuf
  import jfs_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int COL_W   = $clog2(MAX_COLS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic [COL_W-1:0]        col,
  input  logic signed [VAL_W-1:0] old_in,
  input  logic signed [VAL_W-1:0] rhs_in,
  output logic signed [VAL_W-1:0] s1_old,
  output logic signed [VAL_W-1:0] s1_rhs,
  output logic signed [VAL_W-1:0] s1_left,
  output logic signed [VAL_W-1:0] s1_right,
  output logic signed [VAL_W-1:0] s1_up,
  output logic signed [VAL_W-1:0] s1_ctr
);

  logic [VAL_W-1:0] lp_mem   [MAX_COLS];
  logic [VAL_W-1:0] lp2_mem  [MAX_COLS];
  logic [VAL_W-1:0] rhs_mem  [MAX_COLS];

  logic [COL_W-1:0] right_addr;
  logic [VAL_W-1:0] rd_ctr_r;
  logic [VAL_W-1:0] rd_right_r;
  logic [VAL_W-1:0] rd_up_r;
  logic [VAL_W-1:0] rd_rhs_r;
  logic [VAL_W-1:0] left_r;
  logic [VAL_W-1:0] old_r;
  logic [VAL_W-1:0] rhs_in_r;
  logic [COL_W-1:0] wcol_r;
  logic             wb_r;

  // Right neighbour address; the last column's neighbour is never used
  assign right_addr = (col == COL_W'(MAX_COLS - 1)) ? '0 : col + COL_W'(1);

  // Read the column on accept; left neighbour is the previous point's centre
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_ctr_r   <= lp_mem[col];
      rd_right_r <= lp_mem[right_addr];
      rd_up_r    <= lp2_mem[col];
      rd_rhs_r   <= rhs_mem[col];
      left_r     <= rd_ctr_r;
      old_r      <= old_in;
      rhs_in_r   <= rhs_in;
      wcol_r     <= col;
    end
    if (wb_r) begin
      lp2_mem[wcol_r] <= rd_ctr_r;
      lp_mem[wcol_r]  <= old_r;
      rhs_mem[wcol_r] <= rhs_in_r;
    end
  end

  // Write-back strobe, set in the cycle after each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 1'b0;
    end else begin
      wb_r <= acc;
    end
  end

  assign s1_old   = old_r;
  assign s1_rhs   = rd_rhs_r;
  assign s1_left  = left_r;
  assign s1_right = rd_right_r;
  assign s1_up    = rd_up_r;
  assign s1_ctr   = rd_ctr_r;

endmodule

// File: sv/jfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_datapath
// Five-term stencil sum (registered), then the reciprocal-diagonal multiply,
// floor shift and saturation, and assembly of up to two result records.
// ----------------------------------------------------------------------------
module jfs_datapath
  import jfs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_v,
  input  ctl_t                    s1_ctl,
  input  logic signed [VAL_W-1:0] s1_old,
  input  logic signed [VAL_W-1:0] s1_rhs,
  input  logic signed [VAL_W-1:0] s1_left,
  input  logic signed [VAL_W-1:0] s1_right,
  input  logic signed [VAL_W-1:0] s1_up,
  input  logic signed [VAL_W-1:0] s1_ctr,
  input  logic [INV_W-1:0]        inv_diag,
  output logic                    wr_a,
  output res_t                    res_a,
  output logic                    wr_b,
  output res_t                    res_b
);

  localparam int Q_W = PROD_W - INV_SHIFT;

  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     s2_v_r;
  ctl_t                     s2_ctl_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic [VAL_W-1:0]         s2_ctr_r;
  logic [VAL_W-1:0]         s2_old_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    quot;
  logic [VAL_W-1:0]         sat_val;
  logic                     fits;

  // Sum the five stencil terms at full width
  assign sum_nxt = SUM_W'(s1_rhs) + SUM_W'(s1_left) + SUM_W'(s1_right)
                 + SUM_W'(s1_up) + SUM_W'(s1_old);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r <= s1_ctl;
    s2_sum_r <= sum_nxt;
    s2_ctr_r <= s1_ctr;
    s2_old_r <= s1_old;
  end

  // Scale by the reciprocal diagonal; arithmetic shift rounds towards minus
  // infinity, then clamp to the signed 32-bit range
  assign prod = s2_sum_r * $signed({1'b0, inv_diag});
  assign quot = prod[PROD_W-1:INV_SHIFT];
  assign fits = (quot[Q_W-1:VAL_W-1] == '0) || (quot[Q_W-1:VAL_W-1] == '1);

  always_comb begin
    if (fits) begin
      sat_val = quot[VAL_W-1:0];
    end else if (quot[Q_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Assemble the row-above result and the last-row pass-through result
  always_comb begin
    wr_a        = s2_v_r && s2_ctl_r.has_a;
    res_a.value = s2_ctl_r.bnd ? s2_ctr_r : sat_val;
    res_a.row   = s2_ctl_r.row - ROW_OUT_W'(1);
    res_a.col   = s2_ctl_r.col;
    res_a.bnd   = s2_ctl_r.bnd;
    res_a.last  = !s2_ctl_r.has_b;
    res_a.done  = 1'b0;

    wr_b        = s2_v_r && s2_ctl_r.has_b;
    res_b.value = s2_old_r;
    res_b.row   = s2_ctl_r.row;
    res_b.col   = s2_ctl_r.col;
    res_b.bnd   = 1'b1;
    res_b.last  = 1'b1;
    res_b.done  = s2_ctl_r.done;
  end

endmodule

// File: sv/jfs_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_out_fifo
// Small result queue: takes up to two records a cycle, in order, and
// presents the oldest one to the result channel.
// ----------------------------------------------------------------------------
module jfs_out_fifo
  import jfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_a,
  input  res_t                  res_a,
  input  logic                  wr_b,
  input  res_t                  res_b,
  input  logic                  pop,
  output logic                  head_v,
  output res_t                  head,
  output logic [FIFO_CNT_W-1:0] fill
);

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r;
  logic [FIFO_PTR_W-1:0] rptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FIFO_PTR_W-1:0] wptr_b;
  logic [FIFO_CNT_W-1:0] n_wr;
  logic                  do_pop;

  assign wptr_b = wr_a ? wptr_r + FIFO_PTR_W'(1) : wptr_r;
  assign n_wr   = FIFO_CNT_W'(wr_a) + FIFO_CNT_W'(wr_b);
  assign do_pop = pop && (cnt_r != '0);

  // Store the records, row-above result first
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_r[wptr_r] <= res_a;
    end
    if (wr_b) begin
      mem_r[wptr_b] <= res_b;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + FIFO_PTR_W'(n_wr);
      rptr_r <= rptr_r + FIFO_PTR_W'(do_pop);
      cnt_r  <= cnt_r + n_wr - FIFO_CNT_W'(do_pop);
    end
  end

  assign head_v = (cnt_r != '0);
  assign head   = mem_r[rptr_r];
  assign fill   = cnt_r;

endmodule

// File: sv/jacobi_five_point_sweep_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_five_point_sweep_unit
// Streamed Jacobi sweep of a five-point stencil over a raster-ordered grid.
// ----------------------------------------------------------------------------
// Accepts one grid point per clock while in_stall is low. Each point of row
// r yields the new value of the point above it (row r-1); the first row
// yields nothing, and each point of the last row also yields itself as a
// boundary result, so the last row produces two results per point and is
// limited by the result port. A point passes the registered line-memory
// read and stencil sum on its way to the result queue; multiply and
// saturate feed the queue write. Results wait in an eight-entry queue; the
// input stalls while fewer than two queue slots remain unclaimed by points
// in flight. The three line memories (MAX_COLS x 32 each) need no clearing
// after reset: they are filled by the first rows of the grid before their
// read data is used.
// ----------------------------------------------------------------------------
module jacobi_five_point_sweep_unit
  import jfs_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // input requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VAL_W-1:0]     in_old_value,
  input  logic signed [VAL_W-1:0]     in_rhs_term,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_W-1:0]     out_new_value,
  output logic [ROW_OUT_W-1:0]        out_row,
  output logic [COL_OUT_W-1:0]        out_col,
  output logic                        out_is_boundary,
  output logic                        out_run_last,
  output logic                        out_grid_done
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [GCOLS_W-1:0]    grid_cols_r;
  logic [GROWS_W-1:0]    grid_rows_r;
  logic [INV_W-1:0]      inv_diag_r;

  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_nxt;
  logic [ROW_W-1:0]      row_nxt;
  logic [CMP_W-1:0]      ecols;
  logic [CMP_W-1:0]      erows;
  logic [CMP_W-1:0]      col_ext;
  logic [CMP_W-1:0]      row_tmp;
  logic [CMP_W-1:0]      cur_c;
  logic [CMP_W-1:0]      cur_r;
  logic [CMP_W-1:0]      c_inc;
  logic [CMP_W-1:0]      r_inc;
  logic                  col_wrap;
  logic                  col_end;
  logic                  last_row;

  logic                  acc;
  logic                  pop;
  ctl_t                  ctl_nxt;
  logic                  s1_v_r;
  ctl_t                  s1_ctl_r;
  logic [FIFO_CNT_W-1:0] credit_r;
  logic [FIFO_CNT_W-1:0] credit_nxt;
  logic [FIFO_CNT_W-1:0] n_res;

  logic signed [VAL_W-1:0] s1_old;
  logic signed [VAL_W-1:0] s1_rhs;
  logic signed [VAL_W-1:0] s1_left;
  logic signed [VAL_W-1:0] s1_right;
  logic signed [VAL_W-1:0] s1_up;
  logic signed [VAL_W-1:0] s1_ctr;

  logic                  wr_a;
  logic                  wr_b;
  res_t                  res_a;
  res_t                  res_b;
  res_t                  head;
  logic                  head_v;
  logic [FIFO_CNT_W-1:0] fill;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_COLS_RST;
      grid_rows_r <= GRID_ROWS_RST;
      inv_diag_r  <= INV_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata[GCOLS_W-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[GROWS_W-1:0];
        CFG_INV_DIAG:  inv_diag_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size to at least three and to what the line memories and counters hold
  always_comb begin
    if (CMP_W'(grid_cols_r) < CMP_W'(3)) begin
      ecols = CMP_W'(3);
    end else if (CMP_W'(grid_cols_r) > CMP_W'(MAX_COLS)) begin
      ecols = CMP_W'(MAX_COLS);
    end else begin
      ecols = CMP_W'(grid_cols_r);
    end
    if (CMP_W'(grid_rows_r) < CMP_W'(3)) begin
      erows = CMP_W'(3);
    end else if (CMP_W'(grid_rows_r) > CMP_W'(MAX_ROWS)) begin
      erows = CMP_W'(MAX_ROWS);
    end else begin
      erows = CMP_W'(grid_rows_r);
    end
  end

  // Current raster position; wrap counters left past a shrunk grid size
  always_comb begin
    col_ext  = CMP_W'(col_r);
    col_wrap = (col_ext >= ecols);
    cur_c    = col_wrap ? '0 : col_ext;
    row_tmp  = CMP_W'(row_r) + CMP_W'(col_wrap);
    cur_r    = (row_tmp >= erows) ? '0 : row_tmp;

    c_inc    = cur_c + CMP_W'(1);
    col_end  = (c_inc >= ecols);
    r_inc    = cur_r + CMP_W'(1);
    col_nxt  = col_end ? '0 : c_inc[COL_W-1:0];
    if (!col_end) begin
      row_nxt = cur_r[ROW_W-1:0];
    end else if (r_inc >= erows) begin
      row_nxt = '0;
    end else begin
      row_nxt = r_inc[ROW_W-1:0];
    end

    last_row      = (cur_r == erows - CMP_W'(1));
    ctl_nxt.has_a = (cur_r != '0);
    ctl_nxt.has_b = last_row;
    ctl_nxt.bnd   = (cur_r == CMP_W'(1)) || (cur_c == '0) || col_end;
    ctl_nxt.done  = col_end;
    ctl_nxt.row   = cur_r[ROW_OUT_W-1:0];
    ctl_nxt.col   = cur_c[COL_OUT_W-1:0];
    n_res         = FIFO_CNT_W'(ctl_nxt.has_a) + FIFO_CNT_W'(ctl_nxt.has_b);
  end

  // Handshakes: claim queue slots on accept, release them on each result
  assign in_stall   = (credit_r < FIFO_CNT_W'(2));
  assign acc        = in_valid && !in_stall;
  assign pop        = head_v && !out_stall;
  assign credit_nxt = credit_r - (acc ? n_res : '0) + FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      credit_r <= FIFO_CNT_W'(FIFO_DEPTH);
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r   <= acc;
      credit_r <= credit_nxt;
    end
  end

  // Hold the point's control alongside the line-memory read data
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r <= ctl_nxt;
    end
  end

  jfs_linebuf #(
    .MAX_COLS (MAX_COLS)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .col      (cur_c[COL_W-1:0]),
    .old_in   (in_old_value),
    .rhs_in   (in_rhs_term),
    .s1_old   (s1_old),
    .s1_rhs   (s1_rhs),
    .s1_left  (s1_left),
    .s1_right (s1_right),
    .s1_up    (s1_up),
    .s1_ctr   (s1_ctr)
  );

  jfs_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_v     (s1_v_r),
    .s1_ctl   (s1_ctl_r),
    .s1_old   (s1_old),
    .s1_rhs   (s1_rhs),
    .s1_left  (s1_left),
    .s1_right (s1_right),
    .s1_up    (s1_up),
    .s1_ctr   (s1_ctr),
    .inv_diag (inv_diag_r),
    .wr_a     (wr_a),
    .res_a    (res_a),
    .wr_b     (wr_b),
    .res_b    (res_b)
  );

  jfs_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_a   (wr_a),
    .res_a  (res_a),
    .wr_b   (wr_b),
    .res_b  (res_b),
    .pop    (pop),
    .head_v (head_v),
    .head   (head),
    .fill   (fill)
  );

  assign out_valid       = head_v;
  assign out_new_value   = head.value;
  assign out_row         = head.row;
  assign out_col         = head.col;
  assign out_is_boundary = head.bnd;
  assign out_run_last    = head.last;
  assign out_grid_done   = head.done;

`ifndef SYNTHESIS
  // Queued results plus unclaimed slots never exceed the queue
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fill) + 32'(credit_r)) <= FIFO_DEPTH)
    else $error("result queue over-committed");

  // The final grid point is always a boundary result that closes its request
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grid_done |-> out_is_boundary && out_run_last)
    else $error("grid_done on a non-closing result");

  // A queue write of two records only comes from a last-row point
  a_two_writes: assert property (@(posedge clk) disable iff (!rst_n)
    wr_a && wr_b |-> $past(s1_v_r) && !res_a.last)
    else $error("double write without last-row point");
`endif

endmodule
